FILE: design/ttcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcd_pkg: shared types and constants for the timestamp to calendar date block
// Holds the register map, datapath widths and the reciprocal constants that
// replace the divisions of the date and time-of-day arithmetic.
// ----------------------------------------------------------------------------
package ttcd_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int ZONE_W = 17;

  typedef enum logic [0:0] {
    REG_ZONE_OFFSET = 1'b0
  } reg_idx_e;

  localparam logic [ZONE_W-1:0] ZONE_RESET = 17'd25200;

  localparam int STAGES = 8;

  localparam int SECS_PER_DAY = 86400;
  localparam int DAY_DIV_SHR  = 7;
  localparam int DAY_DIV_ODD  = SECS_PER_DAY >> DAY_DIV_SHR;

  // Each quotient is taken as (x * M) >> K with M = ceil(2^K / d) and
  // xmax * d < 2^K, which gives the exact floor quotient.
  localparam int  K_DAY = 35;
  localparam longint M_DAY_L = ((longint'(1) << K_DAY) + DAY_DIV_ODD - 1) / DAY_DIV_ODD;
  localparam logic [25:0] M_DAY = 26'(M_DAY_L);

  localparam int  K_HR = 29;
  localparam longint M_HR_L = ((longint'(1) << K_HR) + 3600 - 1) / 3600;
  localparam logic [17:0] M_HR = 18'(M_HR_L);

  localparam int  K_MIN = 23;
  localparam longint M_MIN_L = ((longint'(1) << K_MIN) + 60 - 1) / 60;
  localparam logic [17:0] M_MIN = 18'(M_MIN_L);

  localparam int  K_YR = 39;
  localparam longint M_YR_L = ((longint'(1) << K_YR) + 7305 - 1) / 7305;
  localparam logic [26:0] M_YR = 27'(M_YR_L);

  localparam int  K_MO = 25;
  localparam longint M_MO_L = ((longint'(1) << K_MO) * 1000 + 30601 - 1) / 30601;
  localparam logic [20:0] M_MO = 21'(M_MO_L);

  localparam int CENT_BASE = 102032;
  localparam int CENT_DIV  = 146097;
  localparam int JD_BASE   = 2442113;
  localparam int YR_OFFSET = 2442;
  localparam int YR_BASE   = 4716;
  localparam int YR_BASE_R = 4715;

  // Integer part of mo * 0.601 for the March-based month index.
  localparam logic [3:0] MO_FRAC [16] = '{
    4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd3, 4'd3, 4'd4,
    4'd4, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd9
  };

endpackage

FILE: design/ttcd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcd_cfg: configuration register file
// Holds the signed time-zone offset behind an APB-style slave port.
// ----------------------------------------------------------------------------
module ttcd_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ttcd_pkg::ADDR_W-1:0]    paddr,
  input  logic [ttcd_pkg::DATA_W-1:0]    pwdata,
  output logic [ttcd_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output logic [ttcd_pkg::ZONE_W-1:0]    zone_offset_o
);

  logic [ttcd_pkg::ZONE_W-1:0] zone_q;
  logic [ttcd_pkg::ZONE_W-1:0] zone_d;
  ttcd_pkg::reg_idx_e          idx;
  logic                        wr_en;

  assign idx    = ttcd_pkg::reg_idx_e'(paddr[ttcd_pkg::ADDR_W-1]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    zone_d = zone_q;
    prdata = '0;
    unique case (idx)
      ttcd_pkg::REG_ZONE_OFFSET: begin
        prdata = {{(ttcd_pkg::DATA_W - ttcd_pkg::ZONE_W){zone_q[ttcd_pkg::ZONE_W-1]}}, zone_q};
        if (wr_en) begin
          zone_d = pwdata[ttcd_pkg::ZONE_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= ttcd_pkg::ZONE_RESET;
    end else begin
      zone_q <= zone_d;
    end
  end

  assign zone_offset_o = zone_q;

endmodule

FILE: design/timestamp_to_calendar_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_to_calendar_date: Unix time to local calendar date and time
// Throughput is one beat per cycle while the output side does not stall; the
// eight-stage datapath holds about one multiplication followed by a short add
// chain in each stage.
// Reset empties the pipeline and loads the zone offset with 25200 s.
// ----------------------------------------------------------------------------
module timestamp_to_calendar_date (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ttcd_pkg::ADDR_W-1:0]    paddr,
  input  logic [ttcd_pkg::DATA_W-1:0]    pwdata,
  output logic [ttcd_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [31:0]                    epoch_seconds_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [4:0]                     hours_o,
  output logic [5:0]                     minutes_o,
  output logic [5:0]                     seconds_o,
  output logic [4:0]                     day_of_month_o,
  output logic [3:0]                     month_o,
  output logic [11:0]                    year_o
);

  localparam int NS = ttcd_pkg::STAGES;

  logic [ttcd_pkg::ZONE_W-1:0] zone;
  logic [NS-1:0]               valid_q;
  logic [NS-1:0]               en;

  ttcd_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .zone_offset_o (zone)
  );

  always_comb begin
    en[NS-1] = !valid_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 1: local second count.
  logic [31:0] t1_d, t1_q;
  assign t1_d = epoch_seconds_i
              + {{(32 - ttcd_pkg::ZONE_W){zone[ttcd_pkg::ZONE_W-1]}}, zone};

  // Stage 2: day number.
  logic [50:0] prod_day;
  logic [15:0] dn2_d, dn2_q;
  logic [31:0] t2_q;
  assign prod_day = 51'(t1_q[31:ttcd_pkg::DAY_DIV_SHR]) * 51'(ttcd_pkg::M_DAY);
  assign dn2_d    = prod_day[ttcd_pkg::K_DAY+15:ttcd_pkg::K_DAY];

  // Stage 3: second of day and Julian day.
  logic [31:0] sod_full;
  logic [16:0] sod3_d, sod3_q;
  logic [18:0] cent_n;
  logic [4:0]  cc;
  logic [4:0]  cc_adj;
  logic [21:0] jd3_d, jd3_q;
  assign sod_full = t2_q - 32'(dn2_q) * 32'(ttcd_pkg::SECS_PER_DAY);
  assign sod3_d   = sod_full[16:0];
  assign cent_n   = 19'({dn2_q, 2'b00}) + 19'(ttcd_pkg::CENT_BASE);
  assign cc       = 5'd15 + 5'(cent_n >= 19'(ttcd_pkg::CENT_DIV))
                          + 5'(cent_n >= 19'(2 * ttcd_pkg::CENT_DIV));
  assign cc_adj   = cc - (cc >> 2);
  assign jd3_d    = 22'(dn2_q) + 22'(ttcd_pkg::JD_BASE) + 22'(cc_adj);

  // Stage 4: hour and minute of day, year numerator.
  logic [34:0] prod_hr, prod_min;
  logic [4:0]  hr4_d, hr4_q;
  logic [10:0] mt4_d, mt4_q;
  logic [16:0] sod4_q;
  logic [25:0] xy4_d, xy4_q;
  logic [21:0] jd4_q;
  assign prod_hr  = 35'(sod3_q) * 35'(ttcd_pkg::M_HR);
  assign prod_min = 35'(sod3_q) * 35'(ttcd_pkg::M_MIN);
  assign hr4_d    = prod_hr[ttcd_pkg::K_HR+4:ttcd_pkg::K_HR];
  assign mt4_d    = prod_min[ttcd_pkg::K_MIN+10:ttcd_pkg::K_MIN];
  assign xy4_d    = 26'(jd3_q) * 26'd20 - 26'(ttcd_pkg::YR_OFFSET);

  // Stage 5: year count, minute and second.
  logic [52:0] prod_yr;
  logic [12:0] yc5_d, yc5_q;
  logic [10:0] mi_full;
  logic [16:0] se_full;
  logic [4:0]  hr5_q;
  logic [5:0]  mi5_q, se5_q;
  logic [21:0] jd5_q;
  assign prod_yr = 53'(xy4_q) * 53'(ttcd_pkg::M_YR);
  assign yc5_d   = prod_yr[ttcd_pkg::K_YR+12:ttcd_pkg::K_YR];
  assign mi_full = mt4_q - 11'(hr4_q) * 11'd60;
  assign se_full = sod4_q - 17'(mt4_q) * 17'd60;

  // Stage 6: day within the March-based year.
  logic [21:0] dy_full;
  logic [9:0]  dy6_q;
  logic [12:0] yc6_q;
  logic [4:0]  hr6_q;
  logic [5:0]  mi6_q, se6_q;
  assign dy_full = jd5_q - 22'(yc5_q) * 22'd365 - 22'(yc5_q >> 2);

  // Stage 7: month index.
  logic [30:0] prod_mo;
  logic [3:0]  mo7_d, mo7_q;
  logic [9:0]  dy7_q;
  logic [12:0] yc7_q;
  logic [4:0]  hr7_q;
  logic [5:0]  mi7_q, se7_q;
  assign prod_mo = 31'(dy6_q) * 31'(ttcd_pkg::M_MO);
  assign mo7_d   = prod_mo[ttcd_pkg::K_MO+3:ttcd_pkg::K_MO];

  // Stage 8: day of month, month and year.
  logic [9:0]  dd_full;
  logic [12:0] yr_full;
  logic [3:0]  mon_d;
  logic [4:0]  hours_q, day_q;
  logic [5:0]  minutes_q, seconds_q;
  logic [3:0]  month_q;
  logic [11:0] year_q;
  assign dd_full = dy7_q - 10'(mo7_q) * 10'd30 - 10'(ttcd_pkg::MO_FRAC[mo7_q]);

  always_comb begin
    if (mo7_q < 4'd14) begin
      yr_full = yc7_q - 13'(ttcd_pkg::YR_BASE);
      mon_d   = mo7_q - 4'd1;
    end else begin
      yr_full = yc7_q - 13'(ttcd_pkg::YR_BASE_R);
      mon_d   = mo7_q - 4'd13;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      t1_q <= t1_d;
    end
    if (en[1]) begin
      t2_q  <= t1_q;
      dn2_q <= dn2_d;
    end
    if (en[2]) begin
      sod3_q <= sod3_d;
      jd3_q  <= jd3_d;
    end
    if (en[3]) begin
      hr4_q  <= hr4_d;
      mt4_q  <= mt4_d;
      sod4_q <= sod3_q;
      xy4_q  <= xy4_d;
      jd4_q  <= jd3_q;
    end
    if (en[4]) begin
      yc5_q <= yc5_d;
      hr5_q <= hr4_q;
      mi5_q <= mi_full[5:0];
      se5_q <= se_full[5:0];
      jd5_q <= jd4_q;
    end
    if (en[5]) begin
      dy6_q <= dy_full[9:0];
      yc6_q <= yc5_q;
      hr6_q <= hr5_q;
      mi6_q <= mi5_q;
      se6_q <= se5_q;
    end
    if (en[6]) begin
      mo7_q <= mo7_d;
      dy7_q <= dy6_q;
      yc7_q <= yc6_q;
      hr7_q <= hr6_q;
      mi7_q <= mi6_q;
      se7_q <= se6_q;
    end
    if (en[7]) begin
      hours_q   <= hr7_q;
      minutes_q <= mi7_q;
      seconds_q <= se7_q;
      day_q     <= dd_full[4:0];
      month_q   <= mon_d;
      year_q    <= yr_full[11:0];
    end
  end

  assign out_valid_o    = valid_q[NS-1];
  assign hours_o        = hours_q;
  assign minutes_o      = minutes_q;
  assign seconds_o      = seconds_q;
  assign day_of_month_o = day_q;
  assign month_o        = month_q;
  assign year_o         = year_q;

  a_no_stall_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output side is free");

  a_sod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] |-> sod4_q < 17'(ttcd_pkg::SECS_PER_DAY))
    else $error("second of day out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hours_o < 5'd24) && (minutes_o < 6'd60) && (seconds_o < 6'd60))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_o >= 4'd1) && (month_o <= 4'd12) && (day_of_month_o != 5'd0)
                    && (year_o >= 12'd1969) && (year_o <= 12'd2106))
    else $error("calendar date out of range");

endmodule

FILE: test/timestamp_to_calendar_date_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_to_calendar_date_tb: self-checking bench for the calendar converter
// Drives Unix timestamps through the valid/stall input with random gaps and
// checks every output beat against a local date predictor. The zone offset is
// reprogrammed over the APB port between phases, including its range extremes,
// random data above the offset field and a write to an unmapped address.
// ----------------------------------------------------------------------------
module timestamp_to_calendar_date_tb;

  localparam int ADDR_W = ttcd_pkg::ADDR_W;
  localparam int DATA_W = ttcd_pkg::DATA_W;
  localparam int ZONE_W = ttcd_pkg::ZONE_W;

  localparam logic [ADDR_W-1:0] ZONE_ADDR     =
    ADDR_W'(4 * int'(ttcd_pkg::REG_ZONE_OFFSET));
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'(ZONE_ADDR + 4);
  localparam int PIPE_DEPTH = ttcd_pkg::STAGES + 4;
  localparam int RANDOM_PER_PHASE = 189;

  typedef struct packed {
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [11:0] year;
  } cal_date_t;

  class date_checker;
    logic [ZONE_W-1:0] zone_offset;
    cal_date_t expected_dates[$];
    int mismatches;

    function new();
      zone_offset = ttcd_pkg::ZONE_RESET;
      mismatches = 0;
    endfunction

    function void set_zone(logic [ZONE_W-1:0] zone);
      zone_offset = zone;
    endfunction

    function cal_date_t to_local_date(logic [31:0] epoch);
      int unsigned t, sod, dn, cc, jd, yc, dy, mo, dd, mon, yr;
      cal_date_t d;
      t = epoch + {{(32-ZONE_W){zone_offset[ZONE_W-1]}}, zone_offset};
      sod = t % 86400;
      dn = t / 86400;
      cc = (dn * 4 + 102032) / 146097 + 15;
      jd = dn + 2442113 + cc - cc / 4;
      yc = (jd * 20 - 2442) / 7305;
      dy = jd - 365 * yc - yc / 4;
      mo = dy * 1000 / 30601;
      dd = dy - mo * 30 - mo * 601 / 1000;
      if (mo < 14) begin
        yr = yc - 4716;
        mon = mo - 1;
      end else begin
        yr = yc - 4715;
        mon = mo - 13;
      end
      d.hours = 5'(sod / 3600);
      d.minutes = 6'((sod % 3600) / 60);
      d.seconds = 6'(t % 60);
      d.day_of_month = 5'(dd);
      d.month = 4'(mon);
      d.year = 12'(yr);
      return d;
    endfunction

    function void note_epoch(logic [31:0] epoch);
      expected_dates.push_back(to_local_date(epoch));
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_date(cal_date_t got);
      cal_date_t want;
      if (expected_dates.size() == 0) begin
        $display("%0t: date beat with no timestamp pending", $time);
        mismatches++;
        return;
      end
      want = expected_dates.pop_front();
      check_field("hours", 32'(want.hours), 32'(got.hours));
      check_field("minutes", 32'(want.minutes), 32'(got.minutes));
      check_field("seconds", 32'(want.seconds), 32'(got.seconds));
      check_field("day_of_month", 32'(want.day_of_month), 32'(got.day_of_month));
      check_field("month", 32'(want.month), 32'(got.month));
      check_field("year", 32'(want.year), 32'(got.year));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [31:0]       epoch_seconds_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [4:0]        hours_o;
  logic [5:0]        minutes_o;
  logic [5:0]        seconds_o;
  logic [4:0]        day_of_month_o;
  logic [3:0]        month_o;
  logic [11:0]       year_o;

  date_checker dates = new();
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;

  timestamp_to_calendar_date i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .epoch_seconds_i(epoch_seconds_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hours_o        (hours_o),
    .minutes_o      (minutes_o),
    .seconds_o      (seconds_o),
    .day_of_month_o (day_of_month_o),
    .month_o        (month_o),
    .year_o         (year_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("timestamp_to_calendar_date test failed");
    $finish;
  end

  function automatic int draw_idle(ref bit quiet);
    if ($urandom_range(0, 39) == 0) begin
      quiet = !quiet;
    end
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [31:0] random_epoch();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return $urandom;
    end else if (pick < 80) begin
      return $urandom_range(0, 49710) * 86400 + $urandom_range(0, 200) - 100;
    end else if (pick < 90) begin
      return $urandom_range(0, 100000);
    end else begin
      return 32'hFFFF_FFFF - $urandom_range(0, 100000);
    end
  endfunction

  // Output side: stall for a random count, then take one beat and check it.
  initial begin
    int n;
    forever begin
      n = draw_idle(recv_quiet);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      dates.check_date({hours_o, minutes_o, seconds_o, day_of_month_o, month_o, year_o});
    end
  end

  task automatic send_epoch(input logic [31:0] epoch);
    int gap;
    gap = draw_idle(send_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      epoch_seconds_i <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    epoch_seconds_i <= epoch;
    do @(posedge clk_i); while (in_stall_o);
    dates.note_epoch(epoch);
  endtask

  task automatic wait_drained();
    while (dates.pending() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data,
                            output logic [DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_zone_readback();
    logic [DATA_W-1:0] rdata;
    apb_access(1'b0, ZONE_ADDR, '0, rdata);
    dates.check_field("zone_offset readback", 32'(dates.zone_offset),
                      32'(rdata[ZONE_W-1:0]));
  endtask

  task automatic program_zone(input logic [ZONE_W-1:0] zone);
    logic [DATA_W-1:0] rdata;
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (PIPE_DEPTH) @(posedge clk_i);
    apb_access(1'b1, ZONE_ADDR, {(DATA_W-ZONE_W)'($urandom), zone}, rdata);
    dates.set_zone(zone);
    check_zone_readback();
    // A write to an unmapped address must leave the offset alone.
    apb_access(1'b1, UNMAPPED_ADDR, $urandom, rdata);
    check_zone_readback();
  endtask

  task automatic run_phase();
    logic [31:0] corner_epochs[] = '{
      32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000,
      32'd59, 32'd60, 32'd3599, 32'd3600, 32'd43200, 32'd86399, 32'd86400,
      32'd68169600, 32'd946684799, 32'd946684800, 32'd951782400, 32'd951868799,
      32'd951868800, 32'd1709164800, 32'd1735689599, 32'd4107542399,
      32'd4107542400, 32'd4294942095, 32'hAAAA_5555
    };
    foreach (corner_epochs[i]) begin
      send_epoch(corner_epochs[i]);
    end
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      if (i == RANDOM_PER_PHASE / 2) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
      send_epoch(random_epoch());
    end
  endtask

  initial begin
    int zone_settings[] = '{-43200, 50400, 0, -65536, 65535, 0};
    int wait_cycles;
    zone_settings[5] = $urandom_range(0, (1 << ZONE_W) - 1);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_zone_readback();
    run_phase();
    foreach (zone_settings[i]) begin
      program_zone(ZONE_W'(zone_settings[i]));
      run_phase();
    end
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (dates.pending() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (PIPE_DEPTH) @(posedge clk_i);
    if (dates.pending() != 0) begin
      $display("%0t: %0d expected dates never arrived", $time, dates.pending());
    end
    if (dates.mismatches == 0 && dates.pending() == 0) begin
      $display("timestamp_to_calendar_date test passed");
    end else begin
      $display("timestamp_to_calendar_date test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ttcd_pkg.sv
design/ttcd_cfg.sv
design/timestamp_to_calendar_date.sv
test/timestamp_to_calendar_date_tb.sv
